>>> sv/lbcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbcc_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int T_BITS = 40;

   typedef logic signed [T_BITS-1:0] tparam_type;

   typedef enum logic [1:0] {
      CLS_MISS   = 2'd0,
      CLS_CROSS  = 2'd1,
      CLS_INSIDE = 2'd2
   } seg_class_type;

   typedef enum logic [1:0] {
      REG_MIN_X = 2'd0,
      REG_MIN_Y = 2'd1,
      REG_MAX_X = 2'd2,
      REG_MAX_Y = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

>>> sv/lbcc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per stage, floor and clamp at the end
module lbcc_div import lbcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [COORD_BITS-1:0] num_mag,
   input  wire logic [COORD_BITS-1:0] den_mag,
   input  wire logic                  neg,
   output tparam_type                 quot
);

   localparam int N = COORD_BITS + FRAC_BITS;
   localparam logic signed [63:0] LIM_HI = (64'sd1 <<< (T_BITS - 1)) - 64'sd2;
   localparam logic signed [63:0] LIM_LO = 64'sd1 - (64'sd1 <<< (T_BITS - 1));

   logic [COORD_BITS-1:0] rem_ff [1:N];
   logic [COORD_BITS-1:0] den_ff [1:N];
   logic [N-1:0]          dvd_ff [1:N];
   logic [N-1:0]          q_ff   [1:N];
   logic                  neg_ff [1:N];
   tparam_type            quot_ff;

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [COORD_BITS-1:0] rem_src, den_src;
      logic [N-1:0]          dvd_src, q_src;
      logic                  neg_src;
      logic [COORD_BITS:0]   rem_sh;
      logic [COORD_BITS+1:0] diff;

      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign den_src = den_mag;
         assign dvd_src = {num_mag, {FRAC_BITS{1'b0}}};
         assign q_src   = '0;
         assign neg_src = neg;
      end else begin : g_next
         assign rem_src = rem_ff[k];
         assign den_src = den_ff[k];
         assign dvd_src = dvd_ff[k];
         assign q_src   = q_ff[k];
         assign neg_src = neg_ff[k];
      end

      assign rem_sh = {rem_src, dvd_src[N-1]};
      assign diff   = {1'b0, rem_sh} - {2'b00, den_src};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= diff[COORD_BITS+1] ? rem_sh[COORD_BITS-1:0]
                                               : diff[COORD_BITS-1:0];
            q_ff[k+1]   <= {q_src[N-2:0], ~diff[COORD_BITS+1]};
            dvd_ff[k+1] <= dvd_src << 1;
            den_ff[k+1] <= den_src;
            neg_ff[k+1] <= neg_src;
         end
      end
   end

   logic signed [63:0] q_val, f_val;

   // floor for a negative quotient: round the magnitude up
   always_comb begin
      q_val = signed'(64'(q_ff[N]));
      if (neg_ff[N]) begin
         f_val = -(q_val + 64'(rem_ff[N] != '0));
      end else begin
         f_val = q_val;
      end
      if (f_val > LIM_HI) begin
         f_val = LIM_HI;
      end else if (f_val < LIM_LO) begin
         f_val = LIM_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= f_val[T_BITS-1:0];
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

>>> sv/line_box_clip_classify.sv
`timescale 1ns / 1ps
`default_nettype none

// Clips a 2D segment against the axis-aligned box in the csr registers (slab method) and
// reports whether the infinite line hits the box, the entry and exit parameters (signed,
// FRAC_BITS fraction bits, floored; most negative code = unbounded below, most positive =
// unbounded above; both 0 on a miss) and a segment class (0 miss, 1 crossing, 2 inside).
// One request is taken every clock while the pipeline is not held; the four restoring
// dividers resolve one quotient bit per stage. The whole pipeline advances together and
// holds while a response waits. Box registers must be written only while no request is
// in flight; the block itself does not enforce this.
module line_box_clip_classify import lbcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // start_x, start_y, end_x, end_y
   input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // line_hit, t_enter, t_exit, segment_class
   output logic [((2*T_BITS+3+7)/8)*8-1:0]           rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [1:0]                           csr_addr,
   input  wire logic [COORD_BITS-1:0]                csr_wdata
);

   localparam int C = COORD_BITS;
   localparam int N = COORD_BITS + FRAC_BITS;
   localparam int L = N + 1;
   localparam int OUT_W = ((2*T_BITS+3+7)/8)*8;
   localparam tparam_type T_NEG = tparam_type'(64'sd1 <<< (T_BITS - 1));
   localparam tparam_type T_POS = ~T_NEG;
   localparam tparam_type T_ONE = tparam_type'(64'sd1 <<< FRAC_BITS);

   typedef struct packed {
      logic dx0;   // no x motion
      logic dy0;   // no y motion
      logic xin;   // start inside x slab
      logic yin;   // start inside y slab
      logic ovl;   // bounding boxes overlap
   } side_type;

   function automatic logic [C-1:0] mag(input logic signed [C:0] v);
      logic signed [C:0] a;
      a = v[C] ? -v : v;
      return a[C-1:0];
   endfunction

   // box registers
   logic signed [C-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '0;
         min_y_ff <= '0;
         max_x_ff <= '0;
         max_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            REG_MIN_X: min_x_ff <= csr_wdata;
            REG_MIN_Y: min_y_ff <= csr_wdata;
            REG_MAX_X: max_x_ff <= csr_wdata;
            REG_MAX_Y: max_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advances as a whole whenever the output slot is free or drains
   logic pipe_en;
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   // stage 1: capture request
   logic                v1_ff;
   logic signed [C-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sx_ff <= req_tdata[C-1:0];
         sy_ff <= req_tdata[2*C-1:C];
         ex_ff <= req_tdata[3*C-1:2*C];
         ey_ff <= req_tdata[4*C-1:3*C];
      end
   end

   // stage 2: directions, edge distances, slab tests
   logic signed [C:0] dx, dy, nxn, nxf, nyn, nyf;
   logic              dxp, dyp;
   side_type          sd_in;

   always_comb begin
      dx  = (C+1)'(ex_ff) - (C+1)'(sx_ff);
      dy  = (C+1)'(ey_ff) - (C+1)'(sy_ff);
      dxp = !dx[C] && (dx != '0);
      dyp = !dy[C] && (dy != '0);
      // near edge is the one met first along the direction
      nxn = (C+1)'(dxp ? min_x_ff : max_x_ff) - (C+1)'(sx_ff);
      nxf = (C+1)'(dxp ? max_x_ff : min_x_ff) - (C+1)'(sx_ff);
      nyn = (C+1)'(dyp ? min_y_ff : max_y_ff) - (C+1)'(sy_ff);
      nyf = (C+1)'(dyp ? max_y_ff : min_y_ff) - (C+1)'(sy_ff);
      sd_in.dx0 = (dx == '0);
      sd_in.dy0 = (dy == '0);
      sd_in.xin = (sx_ff >= min_x_ff) && (sx_ff <= max_x_ff);
      sd_in.yin = (sy_ff >= min_y_ff) && (sy_ff <= max_y_ff);
      // segment bbox misses when both ends lie beyond the same edge
      sd_in.ovl = !((sx_ff > max_x_ff) && (ex_ff > max_x_ff))
               && !((sx_ff < min_x_ff) && (ex_ff < min_x_ff))
               && !((sy_ff > max_y_ff) && (ey_ff > max_y_ff))
               && !((sy_ff < min_y_ff) && (ey_ff < min_y_ff));
   end

   logic [C-1:0] nxn_ff, nxf_ff, nyn_ff, nyf_ff, dxm_ff, dym_ff;
   logic         gxn_ff, gxf_ff, gyn_ff, gyf_ff;
   side_type     sd_ff [0:L];
   logic         vd_ff [0:L];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         nxn_ff <= mag(nxn);
         nxf_ff <= mag(nxf);
         nyn_ff <= mag(nyn);
         nyf_ff <= mag(nyf);
         dxm_ff <= mag(dx);
         dym_ff <= mag(dy);
         gxn_ff <= nxn[C] ^ dx[C];
         gxf_ff <= nxf[C] ^ dx[C];
         gyn_ff <= nyn[C] ^ dy[C];
         gyf_ff <= nyf[C] ^ dy[C];
         sd_ff[0] <= sd_in;
         for (int i = 1; i <= L; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= L; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         vd_ff[0] <= v1_ff;
         for (int i = 1; i <= L; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
   end

   // four parallel dividers, aligned with the side pipe
   tparam_type txn, txf, tyn, tyf;

   lbcc_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_xn (
      .clock(clock), .en(pipe_en), .num_mag(nxn_ff), .den_mag(dxm_ff),
      .neg(gxn_ff), .quot(txn));
   lbcc_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_xf (
      .clock(clock), .en(pipe_en), .num_mag(nxf_ff), .den_mag(dxm_ff),
      .neg(gxf_ff), .quot(txf));
   lbcc_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_yn (
      .clock(clock), .en(pipe_en), .num_mag(nyn_ff), .den_mag(dym_ff),
      .neg(gyn_ff), .quot(tyn));
   lbcc_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_yf (
      .clock(clock), .en(pipe_en), .num_mag(nyf_ff), .den_mag(dym_ff),
      .neg(gyf_ff), .quot(tyf));

   // stage 3: intersect the two slab intervals
   side_type   sdo;
   tparam_type a0, a1, t0_in, t1_in;
   logic       miss_in;

   always_comb begin
      sdo     = sd_ff[L];
      miss_in = 1'b0;
      a0      = T_NEG;
      a1      = T_POS;
      if (!sdo.dx0) begin
         // horizontal line outside the y slab
         miss_in = sdo.dy0 && !sdo.yin;
         a0      = txn;
         a1      = txf;
      end else if (!sdo.dy0) begin
         // vertical line outside the x slab
         miss_in = !sdo.xin;
      end
      t0_in = a0;
      t1_in = a1;
      if (!sdo.dy0) begin
         t0_in = (tyn > a0) ? tyn : a0;
         t1_in = (tyf < a1) ? tyf : a1;
      end
   end

   logic       v3_ff, miss_ff;
   side_type   s3_ff;
   tparam_type t0_ff, t1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (pipe_en) begin
         v3_ff <= vd_ff[L];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         miss_ff <= miss_in;
         s3_ff   <= sdo;
         t0_ff   <= t0_in;
         t1_ff   <= t1_in;
      end
   end

   // stage 4: hit decision, point case, classification
   logic          hit_in;
   tparam_type    te_in, tx_in;
   seg_class_type cls_in;

   always_comb begin
      if (s3_ff.dx0 && s3_ff.dy0) begin
         // degenerate segment: a point
         hit_in = s3_ff.xin && s3_ff.yin;
         te_in  = '0;
         tx_in  = '0;
      end else begin
         hit_in = !miss_ff && !(t0_ff > t1_ff);
         te_in  = hit_in ? t0_ff : '0;
         tx_in  = hit_in ? t1_ff : '0;
      end
      if (!s3_ff.ovl || !hit_in) begin
         cls_in = CLS_MISS;
      end else if ((te_in > T_ONE) || (tx_in < 0)) begin
         cls_in = CLS_MISS;
      end else if ((te_in >= 0) && (tx_in <= T_ONE)) begin
         cls_in = CLS_INSIDE;
      end else begin
         cls_in = CLS_CROSS;
      end
   end

   logic          out_v_ff, hit_ff;
   tparam_type    te_ff, tx_ff;
   seg_class_type cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (pipe_en) begin
         out_v_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         hit_ff <= hit_in;
         te_ff  <= te_in;
         tx_ff  <= tx_in;
         cls_ff <= cls_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = OUT_W'({cls_ff, tx_ff, te_ff, hit_ff});

`ifndef NO_ASSERTIONS
   // a miss reports zero parameters
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !hit_ff |-> (te_ff == '0) && (tx_ff == '0))
      else $error("miss with nonzero parameters");

   // an inside or crossing class needs a hit
   a_class_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (cls_ff != CLS_MISS) |-> hit_ff)
      else $error("segment class without hit");

   // a hit interval is never inverted
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hit_ff |-> !(te_ff > tx_ff))
      else $error("entry after exit");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !v3_ff && !vd_ff[L])
      else $error("valid after reset");
`endif

endmodule

`default_nettype wire
